@@ rtl/mandelbrot_escape_time_top_assert.svh @@
// Assertion macros shared by the checker of mandelbrot_escape_time_top.
// Expects clk and arst_n to be visible where a macro is used.
`ifndef MANDELBROT_ESCAPE_TIME_TOP_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define MBROT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define MBROT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/mbrot_pkg.sv @@
// Package for the Mandelbrot escape-time block: payload structs and fixed widths.
// No dependencies.
`default_nettype none

package mbrot_pkg;

	localparam int CoordWidth = 32;
	localparam int CountWidth = 16;
	localparam int MagWidth   = 64;
	localparam int DigitWidth = 16;

	localparam logic [CountWidth-1:0] MaxIterReset = 16'd256;

	typedef struct packed {
		logic signed [CoordWidth-1:0] c_real;
		logic signed [CoordWidth-1:0] c_imag;
	} point_t;

	typedef struct packed {
		logic [CountWidth-1:0] iteration_count;
		logic                  escaped;
		logic [MagWidth-1:0]   final_mag_sq;
	} result_t;

endpackage

`default_nettype wire

@@ rtl/mbrot_mul.sv @@
// Shared signed multiplier: sign-magnitude, one 16-bit digit of b per cycle.
// Depends on mbrot_pkg (digit width).
`default_nettype none

module mbrot_mul #(
	parameter int OP_WIDTH = 60
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      go,
	input  logic signed [OP_WIDTH:0]  a,
	input  logic signed [OP_WIDTH:0]  b,
	output logic                      done,
	output logic signed [2*OP_WIDTH:0] prod
);

	localparam int DW    = mbrot_pkg::DigitWidth;
	localparam int ND    = (OP_WIDTH + DW - 1) / DW;
	localparam int BW    = ND * DW;
	localparam int ACC_W = OP_WIDTH + BW;
	localparam int CNT_W = (ND > 1) ? $clog2(ND) : 1;
	localparam logic [CNT_W-1:0] LastStep = CNT_W'(ND - 1);

	typedef enum logic [1:0] {
		MS_IDLE,
		MS_RUN,
		MS_FIN
	} mstate_t;

	mstate_t                 state_q;
	logic [OP_WIDTH-1:0]     a_mag;
	logic [OP_WIDTH-1:0]     b_mag;
	logic [OP_WIDTH-1:0]     a_q;
	logic [BW-1:0]           b_q;
	logic                    neg_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [ACC_W-1:0]        acc_q;
	logic [OP_WIDTH+DW-1:0]  partial;
	logic [2*OP_WIDTH-1:0]   mag;

	assign a_mag = OP_WIDTH'(a[OP_WIDTH] ? -a : a);
	assign b_mag = OP_WIDTH'(b[OP_WIDTH] ? -b : b);

	// upper part of the accumulator plus this digit's partial product
	assign partial = {{DW{1'b0}}, acc_q[ACC_W-1 -: OP_WIDTH]} + a_q * b_q[DW-1:0];
	assign mag     = acc_q[2*OP_WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MS_IDLE;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				MS_IDLE: begin
					if (go) begin
						a_q     <= a_mag;
						b_q     <= BW'(b_mag);
						neg_q   <= a[OP_WIDTH] ^ b[OP_WIDTH];
						acc_q   <= '0;
						cnt_q   <= '0;
						state_q <= MS_RUN;
					end
				end
				MS_RUN: begin
					// shift the accumulator down one digit as the partial lands on top
					acc_q <= {partial, acc_q[BW-1:DW]};
					b_q   <= b_q >> DW;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LastStep) begin
						state_q <= MS_FIN;
					end
				end
				MS_FIN: begin
					prod    <= neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
					done    <= 1'b1;
					state_q <= MS_IDLE;
				end
				default: begin
					state_q <= MS_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/mandelbrot_escape_time_top.sv @@
// Mandelbrot escape-time block with main-cardioid and period-2 disk rejection.
// Depends on mbrot_pkg and mbrot_mul (the one shared multiplier).
//
// Channel   Ports                             Transaction
// point     start, busy, point                start && !busy at a rising edge
// result    done, result                      the single cycle done is high
// config    cfg_valid, cfg_ready, cfg_data    cfg_valid && cfg_ready at a rising edge
//
// Every product runs through mbrot_mul. One iteration is three products, x*y, x^2 and
// y^2, plus the add and compare states ST_LOOP, ST_NEW_Y, ST_NEW_X, ST_SUM and ST_TEST.
// A far point skips the cardioid and disk tests, a cardioid or disk hit ends the point
// there, and an escape ends at the bailout test without the last loop check. The receiver
// cannot stall the result.
// Reset idles the sequencer and sets max_iterations to 256. busy stays high until done.
`default_nettype none

module mandelbrot_escape_time_top #(
	parameter int FRAC_BITS = 28
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  mbrot_pkg::point_t                    point,
	output logic                                 done,
	output mbrot_pkg::result_t                   result,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mbrot_pkg::CountWidth-1:0]     cfg_data
);

	localparam int CW   = mbrot_pkg::CoordWidth;
	localparam int CNTW = mbrot_pkg::CountWidth;
	localparam int MAGW = mbrot_pkg::MagWidth;
	// z before a step never exceeds c or the bailout radius
	localparam int XW   = (CW > FRAC_BITS + 12) ? CW : FRAC_BITS + 12;
	// z after a step, before the bailout test
	localparam int NW   = 2 * XW - FRAC_BITS + 2;
	// largest operand magnitude: z after a step, or the cardioid terms
	localparam int AW   = (NW > 2 * FRAC_BITS + 4) ? NW : 2 * FRAC_BITS + 4;
	localparam int OPW  = AW + 1;
	localparam int PW   = 2 * AW + 1;
	localparam int SW   = 2 * AW;
	localparam int MAG_SHIFT = 2 * FRAC_BITS - 20;
	localparam int MW   = SW + 1 - MAG_SHIFT;

	localparam logic signed [XW:0]   Quarter  = (XW + 1)'(1) << (FRAC_BITS - 2);
	localparam logic signed [XW:0]   OneFx    = (XW + 1)'(1) << FRAC_BITS;
	localparam logic signed [NW-1:0] TwoFx    = NW'(1) << (FRAC_BITS + 1);
	localparam logic signed [NW-1:0] NegTwoFx = -TwoFx;
	localparam logic signed [PW-1:0] DiskLim  = PW'(1) << (2 * FRAC_BITS - 4);
	localparam logic [SW:0]          Bailout  = (SW + 1)'(1) << (2 * FRAC_BITS + 20);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ_Y,
		ST_SQ_XM,
		ST_R,
		ST_MUL_QR,
		ST_SQ_P,
		ST_SQ_X,
		ST_LOOP,
		ST_MUL_XY,
		ST_NEW_Y,
		ST_NEW_X,
		ST_SQ_NX,
		ST_SQ_NY,
		ST_SUM,
		ST_TEST
	} state_t;

	typedef enum logic [2:0] {
		OP_SQ_Y,
		OP_SQ_X,
		OP_XY,
		OP_SQ_XM,
		OP_SQ_P,
		OP_QR
	} op_t;

	state_t                  state_q;
	op_t                     op_q;
	logic                    go_q;
	logic signed [CW-1:0]    cr_q;
	logic signed [CW-1:0]    ci_q;
	logic signed [XW:0]      xm_q;
	logic signed [XW:0]      p_q;
	logic signed [NW-1:0]    x_q;
	logic signed [NW-1:0]    y_q;
	logic [SW-1:0]           xx_q;
	logic [SW-1:0]           yy_q;
	logic signed [PW-1:0]    q_q;
	logic signed [PW-1:0]    r_q;
	logic signed [PW-1:0]    xy_q;
	logic signed [PW-1:0]    dif_q;
	logic [SW:0]             s_q;
	logic [CNTW-1:0]         n_q;
	logic [CNTW-1:0]         max_q;

	logic signed [OPW-1:0]   op_a;
	logic signed [OPW-1:0]   op_b;
	logic                    mul_done;
	logic signed [PW-1:0]    prod;
	logic [SW-1:0]           prod_mag;
	logic signed [PW-1:0]    y2_ext;
	logic                    near;
	logic                    inside_card;
	logic                    inside_disk;
	logic [MW-1:0]           mag_shift;
	logic [MAGW-1:0]         mag_sat;

	mbrot_mul #(
		.OP_WIDTH(AW)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go_q),
		.a      (op_a),
		.b      (op_b),
		.done   (mul_done),
		.prod   (prod)
	);

	always_comb begin
		case (op_q)
			OP_SQ_Y: begin
				op_a = OPW'(y_q);
				op_b = OPW'(y_q);
			end
			OP_SQ_X: begin
				op_a = OPW'(x_q);
				op_b = OPW'(x_q);
			end
			OP_XY: begin
				op_a = OPW'(x_q);
				op_b = OPW'(y_q);
			end
			OP_SQ_XM: begin
				op_a = OPW'(xm_q);
				op_b = OPW'(xm_q);
			end
			OP_SQ_P: begin
				op_a = OPW'(p_q);
				op_b = OPW'(p_q);
			end
			OP_QR: begin
				op_a = OPW'(q_q);
				op_b = OPW'(r_q);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign prod_mag = prod[SW-1:0];
	assign y2_ext   = $signed({1'b0, yy_q});

	// z still equals c while this is used
	assign near = (x_q > NegTwoFx) && (x_q < TwoFx) && (y_q > NegTwoFx) && (y_q < TwoFx);

	// q*(q + (x - 1/4)) < y^2/4, with the product of the multiplier on the left
	assign inside_card = prod < (y2_ext <<< (2 * FRAC_BITS - 2));
	assign inside_disk = (prod + y2_ext) < DiskLim;

	assign mag_shift = MW'(s_q >> MAG_SHIFT);
	assign mag_sat   = (|mag_shift[MW-1:MAGW]) ? {MAGW{1'b1}} : mag_shift[MAGW-1:0];

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_SQ_Y;
			go_q    <= 1'b0;
			done    <= 1'b0;
			max_q   <= mbrot_pkg::MaxIterReset;
		end else begin
			go_q <= 1'b0;
			done <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				max_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						cr_q    <= point.c_real;
						ci_q    <= point.c_imag;
						x_q     <= NW'(point.c_real);
						y_q     <= NW'(point.c_imag);
						xm_q    <= (XW + 1)'(point.c_real) - Quarter;
						p_q     <= (XW + 1)'(point.c_real) + OneFx;
						op_q    <= OP_SQ_Y;
						go_q    <= 1'b1;
						state_q <= ST_SQ_Y;
					end
				end
				ST_SQ_Y: begin
					if (mul_done) begin
						yy_q <= prod_mag;
						go_q <= 1'b1;
						// far points skip the bulb test
						if (near) begin
							op_q    <= OP_SQ_XM;
							state_q <= ST_SQ_XM;
						end else begin
							op_q    <= OP_SQ_X;
							state_q <= ST_SQ_X;
						end
					end
				end
				ST_SQ_XM: begin
					if (mul_done) begin
						q_q     <= prod + y2_ext;
						state_q <= ST_R;
					end
				end
				ST_R: begin
					r_q     <= q_q + (PW'(xm_q) <<< FRAC_BITS);
					op_q    <= OP_QR;
					go_q    <= 1'b1;
					state_q <= ST_MUL_QR;
				end
				ST_MUL_QR: begin
					if (mul_done) begin
						if (inside_card) begin
							result  <= '{iteration_count: max_q, escaped: 1'b0,
								final_mag_sq: '0};
							done    <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							op_q    <= OP_SQ_P;
							go_q    <= 1'b1;
							state_q <= ST_SQ_P;
						end
					end
				end
				ST_SQ_P: begin
					if (mul_done) begin
						if (inside_disk) begin
							result  <= '{iteration_count: max_q, escaped: 1'b0,
								final_mag_sq: '0};
							done    <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							op_q    <= OP_SQ_X;
							go_q    <= 1'b1;
							state_q <= ST_SQ_X;
						end
					end
				end
				ST_SQ_X: begin
					if (mul_done) begin
						xx_q    <= prod_mag;
						n_q     <= '0;
						state_q <= ST_LOOP;
					end
				end
				ST_LOOP: begin
					if (n_q == max_q) begin
						result  <= '{iteration_count: max_q, escaped: 1'b0,
							final_mag_sq: '0};
						done    <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						op_q    <= OP_XY;
						go_q    <= 1'b1;
						state_q <= ST_MUL_XY;
					end
				end
				ST_MUL_XY: begin
					if (mul_done) begin
						xy_q    <= prod;
						state_q <= ST_NEW_Y;
					end
				end
				ST_NEW_Y: begin
					// squares of the current z are still held from the last bailout test, or from the initial squares
					dif_q   <= $signed({1'b0, xx_q}) - $signed({1'b0, yy_q});
					y_q     <= NW'(xy_q >>> (FRAC_BITS - 1)) + NW'(ci_q);
					state_q <= ST_NEW_X;
				end
				ST_NEW_X: begin
					x_q     <= NW'(dif_q >>> FRAC_BITS) + NW'(cr_q);
					op_q    <= OP_SQ_X;
					go_q    <= 1'b1;
					state_q <= ST_SQ_NX;
				end
				ST_SQ_NX: begin
					if (mul_done) begin
						xx_q    <= prod_mag;
						op_q    <= OP_SQ_Y;
						go_q    <= 1'b1;
						state_q <= ST_SQ_NY;
					end
				end
				ST_SQ_NY: begin
					if (mul_done) begin
						yy_q    <= prod_mag;
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					s_q     <= {1'b0, xx_q} + {1'b0, yy_q};
					state_q <= ST_TEST;
				end
				ST_TEST: begin
					if (s_q > Bailout) begin
						result  <= '{iteration_count: n_q, escaped: 1'b1,
							final_mag_sq: mag_sat};
						done    <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						n_q     <= n_q + 1'b1;
						state_q <= ST_LOOP;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/mbrot_checker.sv @@
// Port-level checks for mandelbrot_escape_time_top, bound to every instance.
// Depends on mbrot_pkg and mandelbrot_escape_time_top_assert.svh.
`default_nettype none

`include "mandelbrot_escape_time_top_assert.svh"

module mbrot_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input mbrot_pkg::result_t result
);

	`MBROT_ASSERT_NEXT(a_take_busy, start && !busy, busy, "accepted point did not raise busy")
	`MBROT_ASSERT_NEXT(a_single_strobe, done, !done, "result strobe held for two cycles")
	`MBROT_ASSERT_NOW(a_done_idle, done, !busy, "result shown while still busy")
	`MBROT_ASSERT_NOW(a_mag_zero, done && !result.escaped, result.final_mag_sq == '0, "magnitude set on a point that did not escape")

endmodule

bind mandelbrot_escape_time_top mbrot_checker u_mbrot_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

`default_nettype wire

@@ verif/tb_mandelbrot_escape_time_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for mandelbrot_escape_time_top: directed and random points
// under several iteration limits. Depends on mbrot_pkg and the block's RTL.

module tb_mandelbrot_escape_time_top;

	typedef logic signed [127:0] wide_t;

	localparam int FracBits = 28;
	localparam logic signed [mbrot_pkg::CoordWidth-1:0] QOne     = 32'sh1000_0000;
	localparam logic signed [mbrot_pkg::CoordWidth-1:0] QTwo     = 32'sh2000_0000;
	localparam logic signed [mbrot_pkg::CoordWidth-1:0] QQuarter = 32'sh0400_0000;
	localparam logic signed [mbrot_pkg::CoordWidth-1:0] CoordMin = 32'sh8000_0000;
	localparam logic signed [mbrot_pkg::CoordWidth-1:0] CoordMax = 32'sh7FFF_FFFF;
	localparam wide_t Bailout      = 128'sd1 <<< (2 * FracBits + 20);
	localparam wide_t DiskRadiusSq = 128'sd1 <<< (2 * FracBits - 4);
	localparam logic [mbrot_pkg::CountWidth-1:0] StepCap  = 16'd48;
	localparam logic [mbrot_pkg::CountWidth-1:0] TopLimit = 16'hFFFF;
	localparam int ItemTarget    = 1050;
	localparam int MaxReported   = 10;
	localparam int TimeoutCycles = 10_000_000;
	localparam int EndCycles     = 64;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	mbrot_pkg::point_t  point;
	logic               done;
	mbrot_pkg::result_t result;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [mbrot_pkg::CountWidth-1:0] cfg_data;

	logic [mbrot_pkg::CountWidth-1:0] iter_limit = mbrot_pkg::MaxIterReset;
	mbrot_pkg::result_t predicted_results[$];
	mbrot_pkg::result_t oldest_expected;
	bit steady_sender = 1'b0;
	int points_sent  = 0;
	int results_seen = 0;
	int mismatches   = 0;
	int limit_writes = 0;

	mandelbrot_escape_time_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.point     (point),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic wide_t widen(logic [mbrot_pkg::CoordWidth-1:0] v);
		return {{(128 - mbrot_pkg::CoordWidth){v[mbrot_pkg::CoordWidth-1]}}, v};
	endfunction

	function automatic mbrot_pkg::point_t make_point(logic [mbrot_pkg::CoordWidth-1:0] re,
		logic [mbrot_pkg::CoordWidth-1:0] im);
		mbrot_pkg::point_t p;
		p.c_real = re;
		p.c_imag = im;
		return p;
	endfunction

	// Strictly inside the main cardioid or the period-2 disk, tested exactly
	function automatic bit in_bulb(mbrot_pkg::point_t p);
		wide_t cr, ci, xm, y2, q, lhs, rhs, pr;
		cr = widen(p.c_real);
		ci = widen(p.c_imag);
		if (cr >= widen(QTwo) || cr <= -widen(QTwo) || ci >= widen(QTwo) || ci <= -widen(QTwo))
			return 1'b0;
		xm  = cr - widen(QQuarter);
		y2  = ci * ci;
		q   = xm * xm + y2;
		lhs = q * (q + (xm <<< FracBits));
		rhs = y2 <<< (2 * FracBits - 2);
		if (lhs < rhs)
			return 1'b1;
		pr = cr + widen(QOne);
		return (pr * pr + y2) < DiskRadiusSq;
	endfunction

	function automatic mbrot_pkg::result_t predict_escape(mbrot_pkg::point_t p,
		logic [mbrot_pkg::CountWidth-1:0] limit);
		mbrot_pkg::result_t r;
		wide_t cr, ci, x, y, nx, ny, s;
		int n;
		r.iteration_count = limit;
		r.escaped         = 1'b0;
		r.final_mag_sq    = '0;
		if (in_bulb(p))
			return r;
		cr = widen(p.c_real);
		ci = widen(p.c_imag);
		x  = cr;
		y  = ci;
		for (n = 0; n < int'(limit); n++) begin
			nx = ((x * x - y * y) >>> FracBits) + cr;
			ny = ((x * y) >>> (FracBits - 1)) + ci;
			s  = nx * nx + ny * ny;
			if (s > Bailout) begin
				// Q.56 down to Q.20, saturate past 64 bits
				s = s >>> (2 * FracBits - 20);
				r.iteration_count = n[mbrot_pkg::CountWidth-1:0];
				r.escaped         = 1'b1;
				r.final_mag_sq    = (s[127:64] != '0) ? '1 : s[63:0];
				return r;
			end
			x = nx;
			y = ny;
		end
		return r;
	endfunction

	function automatic logic [mbrot_pkg::CoordWidth-1:0] pick_edge_coord();
		case ($urandom_range(0, 9))
			0: return CoordMin;
			1: return CoordMax;
			2: return '0;
			3: return '1;
			4: return 32'd1;
			5: return QTwo;
			6: return QTwo - 1;
			7: return -QTwo;
			8: return -QTwo + 1;
			default: return $urandom;
		endcase
	endfunction

	function automatic mbrot_pkg::point_t gen_point();
		mbrot_pkg::point_t p;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			p.c_real = $urandom;
			p.c_imag = $urandom;
		end else if (pick < 70) begin
			// window around the set: re in [-2.25, 0.75], im in [-1.5, 1.5]
			p.c_real = $urandom_range(0, 3 * QOne) - (2 * QOne + QQuarter);
			p.c_imag = $urandom_range(0, 3 * QOne) - (3 * QOne / 2);
		end else if (pick < 85) begin
			p.c_real = $signed($urandom) >>> $urandom_range(0, 31);
			p.c_imag = $signed($urandom) >>> $urandom_range(0, 31);
		end else begin
			p.c_real = pick_edge_coord();
			p.c_imag = pick_edge_coord();
		end
		return p;
	endfunction

	// Under a high limit keep only points that finish within StepCap iterations
	function automatic mbrot_pkg::point_t choose_point(logic [mbrot_pkg::CountWidth-1:0] limit);
		mbrot_pkg::point_t p;
		mbrot_pkg::result_t trial;
		int tries;
		for (tries = 0; tries < 64; tries++) begin
			p = gen_point();
			if (limit <= StepCap)
				return p;
			trial = predict_escape(p, StepCap);
			if (trial.escaped || in_bulb(p))
				return p;
		end
		// c near 8 escapes within two steps
		return make_point(CoordMax, $urandom);
	endfunction

	task automatic report_mismatch(string what, mbrot_pkg::result_t want,
		mbrot_pkg::result_t got);
		mismatches++;
		if (mismatches <= MaxReported)
			$display("[%0t] %s: expected count %0d escaped %0b mag %h, got count %0d escaped %0b mag %h",
				$time, what, want.iteration_count, want.escaped, want.final_mag_sq,
				got.iteration_count, got.escaped, got.final_mag_sq);
	endtask

	// Hold start high across back-to-back transactions; drop it only to idle
	task automatic send_point(mbrot_pkg::point_t p);
		mbrot_pkg::result_t want;
		want = predict_escape(p, iter_limit);
		while (!steady_sender && $urandom_range(0, 99) < 8) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		point <= p;
		do @(posedge clk); while (busy !== 1'b0);
		predicted_results.insert(predicted_results.size(), want);
		points_sent++;
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (predicted_results.size() != 0 || busy !== 1'b0)
			@(posedge clk);
	endtask

	task automatic write_iter_limit(logic [mbrot_pkg::CountWidth-1:0] value);
		while ($urandom_range(0, 99) < 8)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid  <= 1'b0;
		iter_limit  = value;
		limit_writes++;
	endtask

	task automatic test_default_limit();
		send_point(make_point('0, '0));
		send_point(make_point(-QOne, '0));
		send_point(make_point(QQuarter, '0));
		send_point(make_point(-(3 * QOne / 4), '0));
		send_point(make_point(QQuarter + QOne / 64, '0));
		send_point(make_point(-QOne - QQuarter, '0));
		send_point(make_point(-QOne, QQuarter));
		send_point(make_point('0, QOne));
		send_point(make_point(-QTwo, '0));
		send_point(make_point(-QTwo + 1, '0));
		send_point(make_point(QTwo, '0));
		send_point(make_point(QTwo - 1, '0));
		send_point(make_point('0, QTwo));
		send_point(make_point('0, -QTwo));
		send_point(make_point(CoordMin, CoordMin));
		send_point(make_point(CoordMax, CoordMax));
		send_point(make_point(CoordMin, CoordMax));
		send_point(make_point(CoordMax, CoordMin));
		send_point(make_point(CoordMin, '0));
		send_point(make_point('0, CoordMin));
		send_point(make_point('1, 32'd1));
		send_point(make_point(32'd1, '1));
		wait_idle();
	endtask

	task automatic test_zero_limit();
		int i;
		write_iter_limit('0);
		send_point(make_point('0, '0));
		send_point(make_point(-QTwo, '0));
		send_point(make_point(CoordMax, CoordMax));
		for (i = 0; i < 5; i++)
			send_point(choose_point(iter_limit));
		wait_idle();
	endtask

	task automatic test_single_step();
		int i;
		write_iter_limit(16'd1);
		for (i = 0; i < 30; i++)
			send_point(choose_point(iter_limit));
		wait_idle();
	endtask

	task automatic test_top_limit();
		int i;
		write_iter_limit(TopLimit);
		send_point(make_point('0, '0));
		send_point(make_point(-QOne, '0));
		send_point(make_point(QTwo, '0));
		for (i = 0; i < 37; i++)
			send_point(choose_point(iter_limit));
		wait_idle();
	endtask

	task automatic test_random_limits();
		int phase, i, count;
		int unsigned pick;
		logic [mbrot_pkg::CountWidth-1:0] limit;
		phase = 0;
		while (points_sent < ItemTarget) begin
			pick = $urandom_range(0, 99);
			if (pick < 60)
				limit = $urandom_range(1, 40);
			else if (pick < 85)
				limit = $urandom_range(41, 300);
			else if (pick < 92)
				limit = TopLimit;
			else
				limit = $urandom_range(301, 65534);
			// a long stretch of back-to-back transactions
			steady_sender = (phase >= 2 && phase <= 4);
			write_iter_limit(limit);
			count = $urandom_range(30, 80);
			for (i = 0; i < count; i++)
				send_point(choose_point(iter_limit));
			wait_idle();
			phase++;
		end
		steady_sender = 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			results_seen++;
			if (predicted_results.size() == 0) begin
				report_mismatch("unexpected result", '0, result);
			end else begin
				oldest_expected = predicted_results.pop_front();
				if (result.iteration_count !== oldest_expected.iteration_count
					|| result.escaped !== oldest_expected.escaped
					|| result.final_mag_sq !== oldest_expected.final_mag_sq)
					report_mismatch("result mismatch", oldest_expected, result);
			end
		end
	end

	initial begin
		arst_n    <= 1'b0;
		start     <= 1'b0;
		point     <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_limit();
		test_zero_limit();
		test_single_step();
		test_top_limit();
		test_random_limits();

		wait_idle();
		repeat (EndCycles) @(posedge clk);
		$display("Covered %0d points under %0d iteration limits besides the reset value;",
			points_sent, limit_writes);
		$display("checked %0d results, %0d mismatched", results_seen, mismatches);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#(TimeoutCycles * 12);
		$display("Timeout with %0d results outstanding", predicted_results.size());
		$display("Mismatches found");
		$finish;
	end

endmodule
